/* rtl/rtch_pkg.sv */
// Shared types and constants for the ray/triangle closest-hit block.
// No dependencies; imported by every module of the block.
package rtch_pkg;

	localparam int CRD_W  = 16;   // internal coordinate width after sign extension
	localparam int DIF_W  = 18;   // vertex differences
	localparam int HP_W   = 34;   // direction x edge products and h terms
	localparam int QP_W   = 36;   // origin-offset x edge products and q terms
	localparam int SUM_W  = 56;   // dot-product terms and their sums
	localparam int NUM_W  = 52;   // numerator and denominator of t
	localparam int IDX_W  = 24;   // widest triangle index carried through the queue
	localparam int OIDX_W = 16;   // result index width
	localparam int REG_W  = 16;   // configuration register width
	localparam int CIX_W  = 3;    // configuration index width
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int PROD_W = 2 * NUM_W;
	localparam int HALF_W = NUM_W / 2;

	typedef enum logic [CIX_W-1:0] {
		REG_ORIG_X = 3'd0,
		REG_ORIG_Y = 3'd1,
		REG_ORIG_Z = 3'd2,
		REG_DIR_X  = 3'd3,
		REG_DIR_Y  = 3'd4,
		REG_DIR_Z  = 3'd5
	} reg_idx_t;

	localparam logic [REG_W-1:0] DIR_Z_RESET = 16'd256;

	// One classified triangle on its way from the front to the back.
	typedef struct packed {
		logic             cand;   // passed every hit test
		logic             last;
		logic [NUM_W-1:0] tn;
		logic [NUM_W-1:0] td;
		logic [IDX_W-1:0] idx;
	} rtch_entry_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_MUL  = 2'd1,
		B_FIN  = 2'd2
	} bst_t;

endpackage

/* rtl/rtch_front.sv */
// Front end: configuration registers and the six-stage intersection pipeline.
// Depends on rtch_pkg; feeds rtch_queue.
module rtch_front #(
	parameter int COORD_BITS = 16,
	parameter int INDEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rtch_pkg::CIX_W-1:0]  cfg_index,
	input  logic [rtch_pkg::REG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [COORD_BITS-1:0]       p0_x, p0_y, p0_z,
	input  logic [COORD_BITS-1:0]       p1_x, p1_y, p1_z,
	input  logic [COORD_BITS-1:0]       p2_x, p2_y, p2_z,
	input  logic [INDEX_BITS-1:0]       tri_index,
	input  logic                        last_tri,
	input  logic                        q_full,
	output logic                        push,
	output rtch_pkg::rtch_entry_t       push_entry
);
	import rtch_pkg::*;

	logic [REG_W-1:0] cfg_q [6];
	logic signed [CRD_W-1:0] o [3], d [3], a [3], b [3], c [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;

	logic signed [DIF_W-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [CRD_W-1:0] d_s1 [3];
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	logic signed [DIF_W-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [CRD_W-1:0] d_s2 [3];
	logic signed [HP_W-1:0] hp_s2 [6];
	logic signed [QP_W-1:0] qp_s2 [6];

	logic signed [DIF_W-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [CRD_W-1:0] d_s3 [3];
	logic signed [HP_W-1:0] h_s3 [3];
	logic signed [QP_W-1:0] q_s3 [3];

	logic signed [SUM_W-1:0] dp_s4 [12];
	logic signed [SUM_W-1:0] det_s5, u_s5, v_s5x, t_s5;

	logic signed [SUM_W-1:0] det_n, u_n, v_n, t_n;
	logic signed [SUM_W:0]   uv_n;
	rtch_entry_t             ent_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= '0;
			cfg_q[1] <= '0;
			cfg_q[2] <= '0;
			cfg_q[3] <= '0;
			cfg_q[4] <= '0;
			cfg_q[5] <= DIR_Z_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIG_X: cfg_q[0] <= cfg_data;
				REG_ORIG_Y: cfg_q[1] <= cfg_data;
				REG_ORIG_Z: cfg_q[2] <= cfg_data;
				REG_DIR_X:  cfg_q[3] <= cfg_data;
				REG_DIR_Y:  cfg_q[4] <= cfg_data;
				REG_DIR_Z:  cfg_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o[i] = $signed(cfg_q[i][COORD_BITS-1:0]);
			d[i] = $signed(cfg_q[3+i][COORD_BITS-1:0]);
		end
		a[0] = $signed(p0_x); a[1] = $signed(p0_y); a[2] = $signed(p0_z);
		b[0] = $signed(p1_x); b[1] = $signed(p1_y); b[2] = $signed(p1_z);
		c[0] = $signed(p2_x); c[1] = $signed(p2_y); c[2] = $signed(p2_z);
	end

	// The whole pipeline moves as one; it holds only when the queue cannot take the tail.
	assign adv      = !v_s6 || !q_full;
	assign in_stall = !adv;
	assign push     = v_s6 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= DIF_W'(b[i]) - DIF_W'(a[i]);
				e2_s1[i] <= DIF_W'(c[i]) - DIF_W'(a[i]);
				s_s1[i]  <= DIF_W'(o[i]) - DIF_W'(a[i]);
				d_s1[i]  <= d[i];
			end
			idx_s1  <= IDX_W'(tri_index);
			last_s1 <= last_tri;

			e1_s2 <= e1_s1; e2_s2 <= e2_s1; s_s2 <= s_s1; d_s2 <= d_s1;
			idx_s2 <= idx_s1; last_s2 <= last_s1;
			hp_s2[0] <= d_s1[1] * e2_s1[2];
			hp_s2[1] <= d_s1[2] * e2_s1[1];
			hp_s2[2] <= d_s1[2] * e2_s1[0];
			hp_s2[3] <= d_s1[0] * e2_s1[2];
			hp_s2[4] <= d_s1[0] * e2_s1[1];
			hp_s2[5] <= d_s1[1] * e2_s1[0];
			qp_s2[0] <= s_s1[1] * e1_s1[2];
			qp_s2[1] <= s_s1[2] * e1_s1[1];
			qp_s2[2] <= s_s1[2] * e1_s1[0];
			qp_s2[3] <= s_s1[0] * e1_s1[2];
			qp_s2[4] <= s_s1[0] * e1_s1[1];
			qp_s2[5] <= s_s1[1] * e1_s1[0];

			e1_s3 <= e1_s2; e2_s3 <= e2_s2; s_s3 <= s_s2; d_s3 <= d_s2;
			idx_s3 <= idx_s2; last_s3 <= last_s2;
			for (int i = 0; i < 3; i++) begin
				h_s3[i] <= hp_s2[2*i] - hp_s2[2*i+1];
				q_s3[i] <= qp_s2[2*i] - qp_s2[2*i+1];
			end

			idx_s4 <= idx_s3; last_s4 <= last_s3;
			for (int i = 0; i < 3; i++) begin
				dp_s4[i]   <= e1_s3[i] * h_s3[i];
				dp_s4[3+i] <= s_s3[i]  * h_s3[i];
				dp_s4[6+i] <= d_s3[i]  * q_s3[i];
				dp_s4[9+i] <= e2_s3[i] * q_s3[i];
			end

			idx_s5 <= idx_s4; last_s5 <= last_s4;
			det_s5 <= dp_s4[0] + dp_s4[1]  + dp_s4[2];
			u_s5   <= dp_s4[3] + dp_s4[4]  + dp_s4[5];
			v_s5x  <= dp_s4[6] + dp_s4[7]  + dp_s4[8];
			t_s5   <= dp_s4[9] + dp_s4[10] + dp_s4[11];

			ent_s6.cand <= (det_n != '0) && !u_n[SUM_W-1] && (u_n <= det_n) &&
				!v_n[SUM_W-1] && (uv_n <= (SUM_W+1)'(det_n)) &&
				!t_n[SUM_W-1] && (t_n != '0);
			ent_s6.last <= last_s5;
			ent_s6.tn   <= t_n[NUM_W-1:0];
			ent_s6.td   <= det_n[NUM_W-1:0];
			ent_s6.idx  <= idx_s5;
		end
	end

	// Sign normalisation: a negative determinant flips all four values.
	always_comb begin
		if (det_s5[SUM_W-1]) begin
			det_n = -det_s5; u_n = -u_s5; v_n = -v_s5x; t_n = -t_s5;
		end else begin
			det_n = det_s5; u_n = u_s5; v_n = v_s5x; t_n = t_s5;
		end
		uv_n = (SUM_W+1)'(u_n) + (SUM_W+1)'(v_n);
	end

	assign push_entry = ent_s6;

endmodule

/* rtl/rtch_queue.sv */
// Four-entry queue that decouples the intersection pipeline from the closest-hit tracker.
// Depends on rtch_pkg.
module rtch_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rtch_pkg::rtch_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output rtch_pkg::rtch_entry_t head
);
	import rtch_pkg::*;

	rtch_entry_t mem [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/rtch_back.sv */
// Back end: nearest-hit tracking with a four-step cross-multiply and the result register.
// Depends on rtch_pkg; drains rtch_queue.
module rtch_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rtch_pkg::rtch_entry_t         q_head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [rtch_pkg::OIDX_W-1:0]   hit_index,
	output logic [rtch_pkg::NUM_W-1:0]    hit_t_num,
	output logic [rtch_pkg::NUM_W-1:0]    hit_t_den
);
	import rtch_pkg::*;

	bst_t st_q, st_d;
	rtch_entry_t wrk_q;
	logic [1:0] k_q;
	logic [PROD_W-1:0] acc1_q, acc2_q;
	logic have_q;
	logic [NUM_W-1:0] bnum_q, bden_q;
	logic [IDX_W-1:0] bidx_q;
	logic ov_q, hit_q;
	logic [OIDX_W-1:0] oidx_q;
	logic [NUM_W-1:0] onum_q, oden_q;

	logic mul_en, fin_go, out_free;
	logic [HALF_W-1:0] ap, dp, cp, bp;
	logic [NUM_W-1:0] pp1, pp2;
	logic [PROD_W-1:0] sh1, sh2;
	logic upd, nh;
	logic [NUM_W-1:0] nnum, nden;
	logic [IDX_W-1:0] nidx;

	assign out_free = !ov_q || !out_stall;

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (q_valid) begin
				st_d = (q_head.cand && have_q) ? B_MUL : B_FIN;
			end
			B_MUL: if (k_q == 2'd3) begin
				st_d = B_FIN;
			end
			B_FIN: if (!wrk_q.last || out_free) begin
				st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		mul_en = 1'b0;
		fin_go = 1'b0;
		case (st_q)
			B_IDLE:  pop    = q_valid;
			B_MUL:   mul_en = 1'b1;
			B_FIN:   fin_go = !wrk_q.last || out_free;
			default: ;
		endcase
	end

	// Partial products of tn*best_den and best_num*td, one half-by-half pair per cycle.
	always_comb begin
		ap = k_q[1] ? wrk_q.tn[NUM_W-1:HALF_W] : wrk_q.tn[HALF_W-1:0];
		cp = k_q[1] ? bnum_q[NUM_W-1:HALF_W]   : bnum_q[HALF_W-1:0];
		dp = k_q[0] ? bden_q[NUM_W-1:HALF_W]   : bden_q[HALF_W-1:0];
		bp = k_q[0] ? wrk_q.td[NUM_W-1:HALF_W] : wrk_q.td[HALF_W-1:0];
		pp1 = NUM_W'(ap) * NUM_W'(dp);
		pp2 = NUM_W'(cp) * NUM_W'(bp);
		case (k_q)
			2'd0: begin
				sh1 = PROD_W'(pp1);
				sh2 = PROD_W'(pp2);
			end
			2'd3: begin
				sh1 = PROD_W'(pp1) << NUM_W;
				sh2 = PROD_W'(pp2) << NUM_W;
			end
			default: begin
				sh1 = PROD_W'(pp1) << HALF_W;
				sh2 = PROD_W'(pp2) << HALF_W;
			end
		endcase
	end

	always_comb begin
		upd  = wrk_q.cand && (!have_q || (acc1_q < acc2_q));
		nh   = have_q || upd;
		nnum = upd ? wrk_q.tn  : bnum_q;
		nden = upd ? wrk_q.td  : bden_q;
		nidx = upd ? wrk_q.idx : bidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			k_q    <= '0;
			have_q <= 1'b0;
			bnum_q <= '0;
			bden_q <= '0;
			bidx_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop)
				k_q <= '0;
			else if (mul_en)
				k_q <= k_q + 1'b1;
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			if (fin_go) begin
				if (wrk_q.last) begin
					ov_q   <= 1'b1;
					have_q <= 1'b0;
					bnum_q <= '0;
					bden_q <= '0;
					bidx_q <= '0;
				end else begin
					have_q <= nh;
					bnum_q <= nnum;
					bden_q <= nden;
					bidx_q <= nidx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wrk_q  <= q_head;
			acc1_q <= '0;
			acc2_q <= '0;
		end else if (mul_en) begin
			acc1_q <= acc1_q + sh1;
			acc2_q <= acc2_q + sh2;
		end
		if (fin_go && wrk_q.last) begin
			hit_q  <= nh;
			oidx_q <= nh ? nidx[OIDX_W-1:0] : '0;
			onum_q <= nh ? nnum : '0;
			oden_q <= nh ? nden : '0;
		end
	end

	assign out_valid = ov_q;
	assign hit       = hit_q;
	assign hit_index = oidx_q;
	assign hit_t_num = onum_q;
	assign hit_t_den = oden_q;

endmodule

/* rtl/ray_triangle_closest_hit.sv */
// Top level of the ray/triangle closest-hit block.
// Depends on rtch_pkg, rtch_front, rtch_queue and rtch_back.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | p0_x..p2_z, tri_index, last_tri
//  result  | out_valid | out_stall | hit, hit_index, hit_t_num, hit_t_den
//  config  | cfg_we    | (none)    | cfg_index, cfg_data
//
// The front pipeline takes one triangle per cycle while in_stall is low and classifies it.
// The tracker then moves a triangle that fails the hit tests or meets no kept hit straight
// from its idle state to its finish state, and passes a hit that must be compared with the
// kept one through its multiply state on the way, since the 52-bit cross-multiply runs as four
// 26-bit partial products on one shared multiplier pair; that unit sets the sustained rate.
// Reset clears the queue, the pipeline valids, the running best and the result valid flag;
// the ray registers return to origin zero and direction (0, 0, 1.0).
// A stalled result does not block the front: up to four classified triangles wait in the
// queue and the pipeline holds once it fills.
module ray_triangle_closest_hit #(
	parameter int COORD_BITS = 16,
	parameter int INDEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rtch_pkg::CIX_W-1:0]  cfg_index,
	input  logic [rtch_pkg::REG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [COORD_BITS-1:0]       p0_x,
	input  logic [COORD_BITS-1:0]       p0_y,
	input  logic [COORD_BITS-1:0]       p0_z,
	input  logic [COORD_BITS-1:0]       p1_x,
	input  logic [COORD_BITS-1:0]       p1_y,
	input  logic [COORD_BITS-1:0]       p1_z,
	input  logic [COORD_BITS-1:0]       p2_x,
	input  logic [COORD_BITS-1:0]       p2_y,
	input  logic [COORD_BITS-1:0]       p2_z,
	input  logic [INDEX_BITS-1:0]       tri_index,
	input  logic                        last_tri,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [rtch_pkg::OIDX_W-1:0] hit_index,
	output logic [rtch_pkg::NUM_W-1:0]  hit_t_num,
	output logic [rtch_pkg::NUM_W-1:0]  hit_t_den
);
	import rtch_pkg::*;

	logic        q_full, q_push, q_pop, q_valid;
	rtch_entry_t q_in, q_head;

	// The front computes the determinant and the u, v and t numerators exactly and
	// classifies the triangle; each transfer into the queue carries the verdict.
	rtch_front #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.tri_index(tri_index), .last_tri(last_tri),
		.q_full(q_full), .push(q_push), .push_entry(q_in)
	);

	rtch_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_entry(q_in), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .head(q_head)
	);

	// The back keeps the nearest hit; a later triangle wins only when strictly nearer,
	// so equal distances keep the earlier one. The last triangle of a batch produces
	// one result transfer and clears the running state.
	rtch_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_head(q_head), .pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_index(hit_index),
		.hit_t_num(hit_t_num), .hit_t_den(hit_t_den)
	);

endmodule

/* rtl/rtch_checker.sv */
// Port-level checks for ray_triangle_closest_hit, bound to the top level.
// Depends on rtch_pkg.
module rtch_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        hit,
	input logic [rtch_pkg::OIDX_W-1:0] hit_index,
	input logic [rtch_pkg::NUM_W-1:0]  hit_t_num,
	input logic [rtch_pkg::NUM_W-1:0]  hit_t_den
);
	import rtch_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_index) &&
		$stable(hit_t_num) && $stable(hit_t_den))
		else $error("stalled result changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_index == '0 && hit_t_num == '0 && hit_t_den == '0)
		else $error("miss result carries non-zero fields");

	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> hit_t_den != '0 && hit_t_num != '0)
		else $error("hit result with zero distance terms");

endmodule

bind ray_triangle_closest_hit rtch_checker u_rtch_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_stall(out_stall),
	.hit(hit), .hit_index(hit_index),
	.hit_t_num(hit_t_num), .hit_t_den(hit_t_den)
);

/* test/tb_ray_triangle_closest_hit.sv */
// Self-checking testbench for ray_triangle_closest_hit: drives triangle batches under random
// handshake gaps and checks each closest-hit result against an internal integer predictor.
// Depends on rtch_pkg and the block's RTL only.
module tb_ray_triangle_closest_hit;
	import rtch_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	// Settle time after the last result of a phase: six front stages, a full queue of four
	// triangles in the tracker and some margin.
	localparam int SETTLE_CYCLES = 64;
	// Register indexes beyond the ray registers; writes to them must be ignored.
	localparam logic [CIX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CIX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic [15:0] p [9];    // p0 xyz, p1 xyz, p2 xyz
		logic [15:0] idx;
		logic        last;
	} triangle_t;

	typedef struct {
		logic        hit;
		logic [15:0] index;
		logic [51:0] num;
		logic [51:0] den;
	} closest_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CIX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic [15:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, tri_index;
	logic last_tri;
	logic out_valid, out_stall;
	logic hit;
	logic [15:0] hit_index;
	logic [51:0] hit_t_num, hit_t_den;

	ray_triangle_closest_hit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.tri_index(tri_index), .last_tri(last_tri),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_index(hit_index), .hit_t_num(hit_t_num), .hit_t_den(hit_t_den)
	);

	// Predictor state: the ray as the block should hold it, and the running nearest hit.
	logic [15:0] ray_reg [6];
	logic [51:0] near_num, near_den;
	logic [15:0] near_idx;
	logic        near_valid;
	closest_t    pending_hits [$];

	int errors;
	int cycles;
	int hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is abandoned if it has not finished well beyond the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver side. Short random stalls, the odd long one, and a long hold-off on request
	// from a test, counted here in cycles so that the sender carries on regardless.
	initial begin : result_stall
		int hold_cnt;
		int burst;
		int r;
		hold_cnt = 0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_cnt = hold_request;
				hold_request = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55)
					out_stall <= 1'b0;
				else if (r < 95) begin
					burst = $urandom_range(0, 3);
					out_stall <= 1'b1;
				end else begin
					burst = $urandom_range(10, 60);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// Every result transfer is compared with the oldest expected result.
	always @(posedge clk) begin
		closest_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				$error("result transfer with no result expected");
				errors++;
			end else begin
				want = pending_hits.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					errors++;
				end
				if (hit_index !== want.index) begin
					$error("hit_index: expected %0d, got %0d", want.index, hit_index);
					errors++;
				end
				if (hit_t_num !== want.num) begin
					$error("hit_t_num: expected %0d, got %0d", want.num, hit_t_num);
					errors++;
				end
				if (hit_t_den !== want.den) begin
					$error("hit_t_den: expected %0d, got %0d", want.den, hit_t_den);
					errors++;
				end
			end
		end
	end

	function automatic longint coord(logic [15:0] raw);
		return longint'($signed(raw));
	endfunction

	// Division-free intersection of one accepted triangle with the held ray; keeps the
	// strictly nearest hit and queues the batch result when the triangle closes a batch.
	function automatic void track_triangle(triangle_t tr);
		longint o [3], d [3], a [3], e1 [3], e2 [3], s [3], h [3], q [3];
		longint det, u, v, t;
		logic [103:0] lhs, rhs;
		logic [51:0] tn, td;
		closest_t res;
		for (int k = 0; k < 3; k++) begin
			o[k] = coord(ray_reg[k]);
			d[k] = coord(ray_reg[3 + k]);
			a[k] = coord(tr.p[k]);
			e1[k] = coord(tr.p[3 + k]) - a[k];
			e2[k] = coord(tr.p[6 + k]) - a[k];
			s[k] = o[k] - a[k];
		end
		h[0] = d[1] * e2[2] - d[2] * e2[1];
		h[1] = d[2] * e2[0] - d[0] * e2[2];
		h[2] = d[0] * e2[1] - d[1] * e2[0];
		q[0] = s[1] * e1[2] - s[2] * e1[1];
		q[1] = s[2] * e1[0] - s[0] * e1[2];
		q[2] = s[0] * e1[1] - s[1] * e1[0];
		det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
		u = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
		v = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
		t = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
		if (det < 0) begin
			det = -det;
			u = -u;
			v = -v;
			t = -t;
		end
		if (det != 0 && u >= 0 && u <= det && v >= 0 && u + v <= det && t > 0) begin
			tn = t[51:0];
			td = det[51:0];
			// t/det < kept num/den, by exact cross-multiplication.
			lhs = {52'd0, tn} * {52'd0, near_den};
			rhs = {52'd0, near_num} * {52'd0, td};
			if (!near_valid || lhs < rhs) begin
				near_valid = 1'b1;
				near_num = tn;
				near_den = td;
				near_idx = tr.idx;
			end
		end
		if (tr.last) begin
			res.hit = near_valid;
			res.index = near_valid ? near_idx : 16'd0;
			res.num = near_valid ? near_num : 52'd0;
			res.den = near_valid ? near_den : 52'd0;
			pending_hits.push_back(res);
			near_valid = 1'b0;
			near_num = '0;
			near_den = '0;
			near_idx = '0;
		end
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offers one triangle from the current rising edge; with no gap it returns at the edge of its
	// transfer with valid high so the next is offered at once, else it drops valid for the gap.
	task automatic send_triangle(triangle_t tr, int gap);
		p0_x <= tr.p[0];
		p0_y <= tr.p[1];
		p0_z <= tr.p[2];
		p1_x <= tr.p[3];
		p1_y <= tr.p[4];
		p1_z <= tr.p[5];
		p2_x <= tr.p[6];
		p2_y <= tr.p[7];
		p2_z <= tr.p[8];
		tri_index <= tr.idx;
		last_tri <= tr.last;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		track_triangle(tr);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pause the sender until every expected result has been delivered and the block
	// has had time to finish any triangle still in flight.
	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Loads all six ray registers, plus a write to an unused index that must change nothing.
	task automatic load_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
		logic [15:0] vals [6];
		reg_idx_t ids [6];
		vals = '{ox, oy, oz, dx, dy, dz};
		ids = '{REG_ORIG_X, REG_ORIG_Y, REG_ORIG_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= ids[k];
			cfg_data <= vals[k];
			ray_reg[k] = vals[k];
			@(posedge clk);
		end
		cfg_index <= $urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7;
		cfg_data <= REG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic triangle_t make_triangle(int v [9], int idx, bit last);
		triangle_t tr;
		for (int k = 0; k < 9; k++)
			tr.p[k] = v[k][15:0];
		tr.idx = idx[15:0];
		tr.last = last;
		return tr;
	endfunction

	// A triangle scattered around a point a random distance along the ray, so that a fair
	// share of them is hit; the coordinates wrap freely at sixteen bits.
	function automatic triangle_t aimed_triangle(int radius);
		triangle_t tr;
		longint reach;
		longint centre;
		reach = longint'($urandom_range(16, 1024));
		for (int k = 0; k < 3; k++) begin
			centre = coord(ray_reg[k]) + (coord(ray_reg[3 + k]) * reach) / 256;
			for (int j = 0; j < 3; j++)
				tr.p[3 * j + k] = 16'(centre + $urandom_range(0, 2 * radius) - radius);
		end
		tr.idx = 16'($urandom);
		tr.last = 1'b0;
		return tr;
	endfunction

	function automatic triangle_t noise_triangle();
		triangle_t tr;
		for (int k = 0; k < 9; k++)
			tr.p[k] = 16'($urandom);
		tr.idx = 16'($urandom);
		tr.last = 1'b0;
		return tr;
	endfunction

	// Mostly aimed triangles, some pure noise, and now and then a degenerate copy.
	function automatic triangle_t random_triangle();
		triangle_t tr;
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			tr = aimed_triangle($urandom_range(0, 3) == 0 ? 4096 : 512);
		else if (r < 92)
			tr = noise_triangle();
		else begin
			tr = aimed_triangle(512);
			for (int k = 0; k < 3; k++)
				tr.p[6 + k] = tr.p[3 * $urandom_range(0, 1) + k];
		end
		return tr;
	endfunction

	// Sends random batches of one to eight triangles, ending on a closed batch.
	task automatic random_batches(int count, bit with_gaps);
		triangle_t tr;
		int left;
		left = 0;
		for (int n = 0; n < count || left != 0; n++) begin
			if (left == 0)
				left = $urandom_range(1, 8);
			tr = random_triangle();
			left--;
			tr.last = (left == 0);
			send_triangle(tr, with_gaps ? gap_length() : 0);
		end
	endtask

	// Directed cases with the reset ray: origin at zero looking along +z.
	task automatic test_directed_cases();
		// A triangle two units ahead, straddling the ray; a copy of it (a tie keeps
		// the first); a nearer one that replaces it; one behind the origin.
		send_triangle(make_triangle('{-256, -256, 512, 512, -256, 512, -256, 512, 512},
			10, 0), gap_length());
		send_triangle(make_triangle('{-256, -256, 512, 512, -256, 512, -256, 512, 512},
			11, 0), gap_length());
		send_triangle(make_triangle('{-256, -256, 256, 512, -256, 256, -256, 512, 256},
			12, 0), gap_length());
		send_triangle(make_triangle('{-256, -256, -256, 512, -256, -256, -256, 512, -256},
			13, 1), gap_length());
		// A triangle in a plane containing the ray, and a collapsed one: both rejected.
		send_triangle(make_triangle('{0, -256, 0, 0, 256, 0, 0, 0, 512}, 20, 0), 0);
		send_triangle(make_triangle('{256, 256, 256, 256, 256, 256, 512, 0, 256}, 21, 1), 0);
		// The ray through a vertex and through an edge: the boundary tests are inclusive.
		send_triangle(make_triangle('{0, 0, 768, 512, 0, 768, 0, 512, 768}, 30, 1), 0);
		send_triangle(make_triangle('{-512, 0, 768, 512, 0, 768, 0, 512, 768}, 31, 1), 0);
		// Coordinates at both extremes of the field, and the largest index.
		send_triangle(make_triangle('{-32768, -32768, 32767, 32767, -32768, 32767,
			-32768, 32767, 32767}, 65535, 0), 1);
		send_triangle(make_triangle('{32767, 32767, -32768, -32768, 32767, 32767,
			32767, -32768, -32768}, 0, 0), 1);
		send_triangle(make_triangle('{-32768, -32768, -32768, -32768, -32768, -32768,
			32767, 32767, 32767}, 32768, 1), 1);
		// A batch of one that misses.
		send_triangle(make_triangle('{4096, 4096, 512, 4352, 4096, 512, 4096, 4352, 512},
			40, 1), 0);
		drain();
	endtask

	// A zero direction makes every determinant zero, so nothing can be hit.
	task automatic test_zero_direction();
		triangle_t tr;
		load_ray(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		for (int n = 0; n < 4; n++) begin
			tr = aimed_triangle(512);
			tr.p = '{16'hff00, 16'hff00, 16'h0200, 16'h0200, 16'hff00, 16'h0200,
				16'hff00, 16'h0200, 16'h0200};
			tr.last = (n == 3);
			send_triangle(tr, 0);
		end
		drain();
	endtask

	// Ray registers at their extremes, with random triangles.
	task automatic test_extreme_rays();
		load_ray(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		random_batches(4, 1);
		drain();
		load_ray(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		random_batches(4, 1);
		drain();
	endtask

	// The receiver holds off for a long stretch while triangles keep arriving, so the queue
	// and the front pipeline fill and the input stalls.
	task automatic test_result_backpressure();
		load_ray(16'd0, 16'd0, 16'hfc00, 16'd0, 16'd0, 16'd256);
		hold_request = 600;
		random_batches(40, 0);
		drain();
	endtask

	// Main random part: several rays, most of them well-formed, each with many batches.
	task automatic test_random_rays();
		logic [15:0] r [6];
		for (int phase = 0; phase < 10; phase++) begin
			for (int k = 0; k < 6; k++)
				r[k] = (phase % 3 == 2) ? 16'($urandom) :
					16'($signed($urandom_range(0, k < 3 ? 4096 : 1024)) -
					(k < 3 ? 2048 : 512));
			load_ray(r[0], r[1], r[2], r[3], r[4], r[5]);
			random_batches(125, 1);
			drain();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_request = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ORIG_X;
		cfg_data = '0;
		in_valid = 1'b0;
		{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;
		tri_index = '0;
		last_tri = 1'b0;
		out_stall = 1'b0;
		ray_reg = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, DIR_Z_RESET};
		near_valid = 1'b0;
		near_num = '0;
		near_den = '0;
		near_idx = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_zero_direction();
		test_extreme_rays();
		test_result_backpressure();
		test_random_rays();

		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
